/* sv/sesg_pkg.sv */
package sesg_pkg;

   localparam int unsigned LevelWidth = 12;
   localparam int unsigned EchoWidth  = 8;
   localparam int unsigned StepWidth  = 8;
   localparam int unsigned CountWidth = 9;
   localparam int unsigned ObjWidth   = 6;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 12;

   // near * 10 > span * 3, products of a 9 bit count need 13 bits
   localparam int unsigned RatioWidth = 13;
   localparam logic [3:0] NearWeight = 4'd10;
   localparam logic [1:0] SpanWeight = 2'd3;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_EDGE_THRESHOLD  = 2'd0,
      CSR_NEAR_LIMIT_CM   = 2'd1,
      CSR_MIN_WIDTH_STEPS = 2'd2,
      CSR_OBJECT_LIMIT    = 2'd3
   } csr_index_type;

   localparam logic [LevelWidth-1:0] EdgeThresholdReset = 12'd200;
   localparam logic [EchoWidth-1:0]  NearLimitReset     = 8'd100;
   localparam logic [StepWidth-1:0]  MinWidthReset      = 8'd4;
   localparam logic [ObjWidth-1:0]   ObjectLimitReset   = 6'd20;

   typedef struct packed {
      logic [LevelWidth-1:0] edge_threshold;
      logic [EchoWidth-1:0]  near_limit_cm;
      logic [StepWidth-1:0]  min_width_steps;
      logic [ObjWidth-1:0]   object_limit;
   } cfg_type;

   typedef struct packed {
      logic [LevelWidth-1:0] previous_level;
      logic [StepWidth-1:0]  step_index;
      logic                  inside_object;
      logic [StepWidth-1:0]  open_start;
      logic [CountWidth-1:0] near_count;
      logic [CountWidth-1:0] span_count;
      logic [ObjWidth-1:0]   objects_found;
   } seg_state_type;

   typedef struct packed {
      logic [LevelWidth-1:0] ir_level;
      logic [EchoWidth-1:0]  echo_cm;
      logic                  last_sample;
   } sample_type;

   typedef struct packed {
      logic [StepWidth-1:0] start_step;
      logic [StepWidth-1:0] end_step;
      logic [StepWidth-1:0] middle_step;
      logic                 cut_by_sweep_end;
   } object_type;

endpackage

/* sv/sesg_csr.sv */
module sesg_csr import sesg_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wr_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_EDGE_THRESHOLD:  cfg_in.edge_threshold  = csr_wr_data[LevelWidth-1:0];
            CSR_NEAR_LIMIT_CM:   cfg_in.near_limit_cm   = csr_wr_data[EchoWidth-1:0];
            CSR_MIN_WIDTH_STEPS: cfg_in.min_width_steps = csr_wr_data[StepWidth-1:0];
            CSR_OBJECT_LIMIT:    cfg_in.object_limit    = csr_wr_data[ObjWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.edge_threshold  <= EdgeThresholdReset;
         cfg_ff.near_limit_cm   <= NearLimitReset;
         cfg_ff.min_width_steps <= MinWidthReset;
         cfg_ff.object_limit    <= ObjectLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/sesg_step.sv */
module sesg_step import sesg_pkg::*; #(
   parameter logic [StepWidth-1:0] LAST_INDEX = 8'd180
) (
   input  cfg_type       cfg,
   input  seg_state_type cur,
   input  sample_type    sample,
   output seg_state_type nxt,
   output logic          produced,
   output object_type    obj
);

   logic                  rise;
   logic                  fall;
   logic                  near_hit;
   logic [LevelWidth-1:0] up_diff;
   logic [LevelWidth-1:0] down_diff;
   logic [StepWidth-1:0]  end_idx;
   logic [StepWidth-1:0]  width;
   logic [RatioWidth-1:0] near_scaled;
   logic [RatioWidth-1:0] span_scaled;
   logic                  echo_ok;
   logic [StepWidth:0]    mid_sum;
   logic                  sweep_end;

   always_comb begin
      up_diff   = sample.ir_level - cur.previous_level;
      down_diff = cur.previous_level - sample.ir_level;
      rise = (sample.ir_level > cur.previous_level) && (up_diff > cfg.edge_threshold);
      fall = (cur.previous_level > sample.ir_level) && (down_diff > cfg.edge_threshold);
      near_hit = sample.echo_cm < cfg.near_limit_cm;

      end_idx = cur.step_index - 8'd1;
      width   = end_idx - cur.open_start;
      near_scaled = RatioWidth'(cur.near_count) * RatioWidth'(NearWeight);
      span_scaled = RatioWidth'(cur.span_count) * RatioWidth'(SpanWeight);
      echo_ok = (cur.span_count != '0) && (near_scaled > span_scaled);

      nxt      = cur;
      produced = 1'b0;
      obj      = '0;

      if (cur.step_index != '0) begin
         if (!cur.inside_object && rise) begin
            nxt.inside_object = 1'b1;
            nxt.open_start    = cur.step_index;
            nxt.span_count    = CountWidth'(1);
            nxt.near_count    = CountWidth'(near_hit);
         end else if (cur.inside_object && fall) begin
            if (echo_ok && width >= cfg.min_width_steps
                && cur.objects_found < cfg.object_limit) begin
               produced             = 1'b1;
               obj.start_step       = cur.open_start;
               obj.end_step         = end_idx;
               obj.cut_by_sweep_end = 1'b0;
               nxt.objects_found    = cur.objects_found + 6'd1;
            end
            nxt.inside_object = 1'b0;
         end else if (cur.inside_object) begin
            // counters saturate
            if (cur.span_count != '1) begin
               nxt.span_count = cur.span_count + 9'd1;
            end
            if (near_hit && cur.near_count != '1) begin
               nxt.near_count = cur.near_count + 9'd1;
            end
         end
      end
      nxt.previous_level = sample.ir_level;

      sweep_end = sample.last_sample || (cur.step_index >= LAST_INDEX);
      if (sweep_end) begin
         // an object still open is reported as cut off while the object limit allows
         if (nxt.inside_object && nxt.objects_found < cfg.object_limit) begin
            produced             = 1'b1;
            obj.start_step       = nxt.open_start;
            obj.end_step         = cur.step_index;
            obj.cut_by_sweep_end = 1'b1;
         end
         nxt.step_index    = '0;
         nxt.inside_object = 1'b0;
         nxt.open_start    = '0;
         nxt.near_count    = '0;
         nxt.span_count    = '0;
         nxt.objects_found = '0;
      end else begin
         nxt.step_index = cur.step_index + 8'd1;
      end

      mid_sum = {1'b0, obj.start_step} + {1'b0, obj.end_step};
      obj.middle_step = mid_sum[StepWidth:1];
   end

endmodule

/* sv/scan_edge_object_segmenter.sv */
// Edge based object segmenter for one sweep of IR/echo samples. Samples enter through a
// valid/stall input register, one step's segmentation logic runs between that register and
// a result register, and a new sample can be taken every clock cycle while req_stall is
// low; a reported object is registered when its sample leaves the input register. The
// result register holds a reported object while rsp_stall is high, and samples that
// report nothing keep flowing meanwhile. At most one object is reported per sample. A
// sweep also ends at step SWEEP_STEPS-1 without the last_sample mark. The user must write
// configuration through the csr_ port only while idle; the block does not enforce it.
module scan_edge_object_segmenter import sesg_pkg::*; #(
   parameter int unsigned SWEEP_STEPS = 181
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [LevelWidth-1:0]   req_ir_level,
   input  logic [EchoWidth-1:0]    req_echo_cm,
   input  logic                    req_last_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [StepWidth-1:0]    rsp_start_step,
   output logic [StepWidth-1:0]    rsp_end_step,
   output logic [StepWidth-1:0]    rsp_middle_step,
   output logic                    rsp_cut_by_sweep_end,
   input  logic                    csr_wr_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wr_data
);

   localparam logic [StepWidth-1:0] LastIndex = StepWidth'(SWEEP_STEPS - 1);

   cfg_type       cfg;
   seg_state_type state_ff;
   seg_state_type state_in;
   seg_state_type step_nxt;
   logic          in_valid_ff;
   logic          in_valid_in;
   sample_type    in_sample_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   object_type    out_obj_ff;
   object_type    step_obj;
   logic          step_produced;
   logic          advance;
   logic          req_take;

   sesg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   sesg_step #(
      .LAST_INDEX (LastIndex)
   ) u_step (
      .cfg      (cfg),
      .cur      (state_ff),
      .sample   (in_sample_ff),
      .nxt      (step_nxt),
      .produced (step_produced),
      .obj      (step_obj)
   );

   // a sample with no result may pass even while the result register is held
   assign advance   = in_valid_ff && (!step_produced || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance && step_produced) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      state_in = advance ? step_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff.ir_level    <= req_ir_level;
         in_sample_ff.echo_cm     <= req_echo_cm;
         in_sample_ff.last_sample <= req_last_sample;
      end
      if (advance && step_produced) begin
         out_obj_ff <= step_obj;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_start_step       = out_obj_ff.start_step;
   assign rsp_end_step         = out_obj_ff.end_step;
   assign rsp_middle_step      = out_obj_ff.middle_step;
   assign rsp_cut_by_sweep_end = out_obj_ff.cut_by_sweep_end;

endmodule
